/* hdl/wsmfb_pkg.sv */
package wsmfb_pkg;

    localparam int LENGTH_WIDTH_DEF = 32;
    localparam int PAY_LEN_W        = 32;
    localparam int HDR_BYTES        = 14;
    localparam int HDR_CNT_W        = $clog2(HDR_BYTES + 1);

    localparam logic        REQ_START = 1'b0;
    localparam logic        REQ_DATA  = 1'b1;

    localparam logic [31:0] KEY_RESET     = 32'h1234_5678;
    localparam logic [7:0]  HDR_OP_BINARY = 8'h82;
    localparam logic [7:0]  MASK_BIT      = 8'h80;
    localparam logic [6:0]  LEN_CODE_16   = 7'd126;
    localparam logic [6:0]  LEN_CODE_64   = 7'd127;
    localparam logic [31:0] LEN_MAX_7     = 32'd125;

    localparam logic [HDR_CNT_W-1:0] HDR_N_SHORT  = HDR_CNT_W'(6);
    localparam logic [HDR_CNT_W-1:0] HDR_N_MEDIUM = HDR_CNT_W'(8);
    localparam logic [HDR_CNT_W-1:0] HDR_N_LONG   = HDR_CNT_W'(14);

    typedef struct packed {
        logic load;
        logic pop;
    } hdr_ctrl_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
        logic       zero_len;
    } hdr_stat_t;

endpackage

/* hdl/wsmfb_if.sv */
interface wsmfb_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [wsmfb_pkg::PAY_LEN_W-1:0] frame_len;
    logic [7:0]                     payload_byte;

    modport source (output valid, output req_type, output frame_len,
                    output payload_byte, input ready);
    modport sink   (input valid, input req_type, input frame_len,
                    input payload_byte, output ready);
endinterface

interface wsmfb_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic       last_of_item;
    logic       sequence_error;

    modport source (output valid, output frame_byte, output last_of_frame,
                    output last_of_item, output sequence_error, input ready);
    modport sink   (input valid, input frame_byte, input last_of_frame,
                    input last_of_item, input sequence_error, output ready);
endinterface

/* hdl/wsmfb_hdr_shift.sv */
module wsmfb_hdr_shift (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wsmfb_pkg::hdr_ctrl_t  ctrl,
    input  logic [31:0]           len,
    input  logic [31:0]           key,
    output wsmfb_pkg::hdr_stat_t  stat
);
    import wsmfb_pkg::*;

    logic [HDR_BYTES*8-1:0] shift_reg;
    logic [HDR_BYTES*8-1:0] image;
    logic [HDR_CNT_W-1:0]   cnt_reg;
    logic [HDR_CNT_W-1:0]   cnt_load;
    logic                   zero_reg;

    // Header image, first byte in the top lane
    always_comb
    begin
        if (len <= LEN_MAX_7)
        begin
            image    = {HDR_OP_BINARY, MASK_BIT | len[7:0], key, 64'h0};
            cnt_load = HDR_N_SHORT;
        end
        else if (len[31:16] == 16'h0)
        begin
            image    = {HDR_OP_BINARY, MASK_BIT | {1'b0, LEN_CODE_16}, len[15:0], key, 48'h0};
            cnt_load = HDR_N_MEDIUM;
        end
        else
        begin
            image    = {HDR_OP_BINARY, MASK_BIT | {1'b0, LEN_CODE_64}, 32'h0, len, key};
            cnt_load = HDR_N_LONG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= cnt_load;
        end
        else if (ctrl.pop)
        begin
            cnt_reg <= cnt_reg - HDR_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            shift_reg <= image;
            zero_reg  <= (len == 32'h0);
        end
        else if (ctrl.pop)
        begin
            shift_reg <= {shift_reg[HDR_BYTES*8-9:0], 8'h0};
        end
    end

    assign stat.frame_byte = shift_reg[HDR_BYTES*8-1 -: 8];
    assign stat.last       = (cnt_reg == HDR_CNT_W'(1));
    assign stat.zero_len   = zero_reg;

endmodule

/* hdl/wsmfb_mask_rot.sv */
module wsmfb_mask_rot (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_we,
    input  logic [31:0] key_wdata,
    input  logic        restart,
    input  logic        advance,
    input  logic [7:0]  data_in,
    output logic [31:0] key,
    output logic [7:0]  data_out
);
    import wsmfb_pkg::*;

    logic [31:0] key_reg;
    logic [1:0]  idx_reg;
    logic [4:0]  lane;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else if (key_we)
        begin
            key_reg <= key_wdata;
        end
    end

    // Step to the next key byte per payload byte; realign at frame start and end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (restart)
        begin
            idx_reg <= '0;
        end
        else if (advance)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Key byte 0 sits in the top lane
    assign lane     = {~idx_reg, 3'b000};
    assign key      = key_reg;
    assign data_out = data_in ^ key_reg[lane +: 8];

endmodule

/* hdl/websocket_masked_frame_builder.sv */
// Masked WebSocket binary frame builder. A start transaction (req_type 0) loads the
// header shift register, which sends 6, 8 or 14 header bytes (two-byte, 16-bit or
// 64-bit length form, then the four mask key bytes) one byte per cycle while the
// output is not stalled; the input is not ready until the last header byte is sent.
// A payload transaction (req_type 1) is taken every cycle while the output register
// drains, and leaves as one byte XORed with the mask key byte picked by a 2-bit
// running index. An out-of-order transaction yields one byte with sequence_error set.
// The user must write the mask key through key_we/key_wdata only while no transaction
// is in flight; the block itself does not enforce it. The key resets to 0x12345678.
module websocket_masked_frame_builder #(
    parameter int LENGTH_WIDTH = wsmfb_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_we,
    input  logic [31:0] key_wdata,
    wsmfb_req_if.sink   req,
    wsmfb_frm_if.source frm
);
    import wsmfb_pkg::*;

    localparam int CntW = (LENGTH_WIDTH < PAY_LEN_W) ? LENGTH_WIDTH : PAY_LEN_W;

    typedef enum logic {ST_IDLE, ST_HDR} state_t;

    state_t          state_reg;
    logic            frame_open_reg;
    logic [CntW-1:0] cnt_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_lof_reg;
    logic            out_loi_reg;
    logic            out_err_reg;

    logic            out_free;
    logic            accept;
    logic            start_ok;
    logic            data_ok;
    logic            seq_err;
    logic            data_end;
    logic [CntW-1:0] len_cut;
    logic [31:0]     len32;
    logic [31:0]     key;
    logic [7:0]      masked_byte;
    hdr_ctrl_t       hdr_ctrl;
    hdr_stat_t       hdr_stat;

    assign out_free  = !out_valid_reg || frm.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign start_ok  = accept && (req.req_type == REQ_START) && !frame_open_reg;
    assign data_ok   = accept && (req.req_type == REQ_DATA) && frame_open_reg;
    assign seq_err   = accept && !start_ok && !data_ok;
    assign data_end  = data_ok && (cnt_reg == CntW'(1));
    assign len_cut   = req.frame_len[CntW-1:0];
    assign len32     = 32'(len_cut);

    assign hdr_ctrl.load = start_ok;
    assign hdr_ctrl.pop  = (state_reg == ST_HDR) && out_free;

    wsmfb_hdr_shift u_hdr (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hdr_ctrl),
        .len   (len32),
        .key   (key),
        .stat  (hdr_stat)
    );

    wsmfb_mask_rot u_mask (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_we    (key_we),
        .key_wdata (key_wdata),
        .restart   (start_ok || data_end),
        .advance   (data_ok),
        .data_in   (req.payload_byte),
        .key       (key),
        .data_out  (masked_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            frame_open_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_ok)
                    begin
                        state_reg <= ST_HDR;
                        if (len_cut != '0)
                        begin
                            frame_open_reg <= 1'b1;
                            cnt_reg        <= len_cut;
                        end
                    end
                    else if (data_ok)
                    begin
                        cnt_reg <= cnt_reg - CntW'(1);
                        if (data_end)
                        begin
                            frame_open_reg <= 1'b0;
                        end
                    end
                end
                ST_HDR:
                begin
                    if (hdr_ctrl.pop && hdr_stat.last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (seq_err || data_ok || hdr_ctrl.pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (seq_err)
        begin
            out_byte_reg <= 8'h0;
            out_lof_reg  <= 1'b0;
            out_loi_reg  <= 1'b1;
            out_err_reg  <= 1'b1;
        end
        else if (data_ok)
        begin
            out_byte_reg <= masked_byte;
            out_lof_reg  <= data_end;
            out_loi_reg  <= 1'b1;
            out_err_reg  <= 1'b0;
        end
        else if (hdr_ctrl.pop)
        begin
            out_byte_reg <= hdr_stat.frame_byte;
            out_lof_reg  <= hdr_stat.last && hdr_stat.zero_len;
            out_loi_reg  <= hdr_stat.last;
            out_err_reg  <= 1'b0;
        end
    end

    assign frm.valid          = out_valid_reg;
    assign frm.frame_byte     = out_byte_reg;
    assign frm.last_of_frame  = out_lof_reg;
    assign frm.last_of_item   = out_loi_reg;
    assign frm.sequence_error = out_err_reg;

`ifndef NO_ASSERTIONS
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> (cnt_reg != '0))
        else $error("frame open with no bytes remaining");

    a_start_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        start_ok |=> (state_reg == ST_HDR))
        else $error("start transaction did not enter header state");

    a_hdr_done: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_ctrl.pop && hdr_stat.last) |=> (state_reg == ST_IDLE) && out_loi_reg)
        else $error("header end not followed by idle");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (frm.valid && frm.sequence_error) |->
            (frm.frame_byte == 8'h0) && frm.last_of_item && !frm.last_of_frame)
        else $error("malformed error byte");
`endif

endmodule
